@@ design/kcl_pkg.sv @@
package kcl_pkg;

	// Default sizes of the code buffer and the slot table
	localparam int DefCodeDigits = 4;
	localparam int DefCodeSlots  = 10;
	localparam int SlotsMax      = 10;
	localparam int DigitsMax     = 4;

	// Field widths
	localparam int DigitW   = 4;
	localparam int SlotW    = 18;
	localparam int RegW     = 54;
	localparam int TimeW    = 16;
	localparam int IdleW    = 17;
	localparam int ToneW    = 3;
	localparam int LenW     = 3;
	localparam int CfgIdxW  = 3;
	localparam int InDataW  = 8;
	localparam int OutDataW = 40;

	localparam logic [IdleW-1:0] IdleMax      = '1;
	localparam logic [TimeW-1:0] IdleTimeoutRst = 16'(1000 * 30);

	// Key codes
	localparam logic [3:0] KeyLastDigit = 4'd9;
	localparam logic [3:0] KeyDelete    = 4'd10;
	localparam logic [3:0] KeyConfirm   = 4'd11;
	localparam logic [3:0] KeyFamLeft   = 4'd12;
	localparam logic [3:0] KeyFamRight  = 4'd13;

	// Tones
	localparam logic [ToneW-1:0] ToneNone  = 3'd0;
	localparam logic [ToneW-1:0] ToneBeep  = 3'd1;
	localparam logic [ToneW-1:0] ToneOk    = 3'd2;
	localparam logic [ToneW-1:0] ToneEmpty = 3'd3;
	localparam logic [ToneW-1:0] ToneErr   = 3'd4;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SLOTS_A   = 3'd0,
		CFG_SLOTS_B   = 3'd1,
		CFG_SLOTS_C   = 3'd2,
		CFG_SLOT_LAST = 3'd3,
		CFG_ONE_TIME  = 3'd4,
		CFG_TWO_TIME  = 3'd5,
		CFG_TIMEOUT   = 3'd6
	} cfg_idx_t;

	// Decoded action of one input word
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_TICK,
		ACT_DIGIT,
		ACT_DELETE,
		ACT_CONFIRM,
		ACT_OTHER
	} act_t;

	typedef struct packed {
		act_t              act;
		logic [DigitW-1:0] digit;
	} cmd_t;

	// Queue to back end handshake
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

@@ design/kcl_front.sv @@
module kcl_front (
	input  logic                         opcode,
	input  logic [3:0]                   key_code,
	input  logic                         key_pressed,
	output kcl_pkg::cmd_t                cmd
);

	// Classify the word into one back-end action
	always_comb begin
		cmd.digit = key_code;
		if (opcode) begin
			cmd.act = kcl_pkg::ACT_TICK;
		end else if (!key_pressed) begin
			cmd.act = kcl_pkg::ACT_NONE;
		end else if (key_code == kcl_pkg::KeyDelete) begin
			cmd.act = kcl_pkg::ACT_DELETE;
		end else if (key_code == kcl_pkg::KeyConfirm) begin
			cmd.act = kcl_pkg::ACT_CONFIRM;
		end else if (key_code == kcl_pkg::KeyFamLeft || key_code == kcl_pkg::KeyFamRight) begin
			cmd.act = kcl_pkg::ACT_NONE;
		end else if (key_code <= kcl_pkg::KeyLastDigit) begin
			cmd.act = kcl_pkg::ACT_DIGIT;
		end else begin
			cmd.act = kcl_pkg::ACT_OTHER;
		end
	end

endmodule

@@ design/kcl_queue.sv @@
module kcl_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  kcl_pkg::cmd_t         push_cmd,
	output logic                  full,
	input  logic                  pop,
	output kcl_pkg::cmd_chan_t    head
);

	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	kcl_pkg::cmd_t         entry_q [2];

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ design/kcl_back.sv @@
module kcl_back #(
	parameter int CODE_DIGITS = kcl_pkg::DefCodeDigits,
	parameter int CODE_SLOTS  = kcl_pkg::DefCodeSlots
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kcl_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [kcl_pkg::RegW-1:0]      cfg_data,
	input  kcl_pkg::cmd_chan_t            head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kcl_pkg::OutDataW-1:0]  out_data
);

	localparam int CntW = $clog2(CODE_DIGITS + 1);
	localparam int IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
	localparam logic [CntW-1:0] Full = CntW'(CODE_DIGITS);

	// Configuration registers
	logic [kcl_pkg::RegW-1:0]  slots_a_q, slots_b_q, slots_c_q;
	logic [kcl_pkg::SlotW-1:0] slot_last_q;
	logic [kcl_pkg::TimeW-1:0] one_time_q, two_time_q, timeout_q;

	// Entry state
	logic [kcl_pkg::DigitW-1:0] digits_q [CODE_DIGITS];
	logic [CntW-1:0]            count_q;
	logic [kcl_pkg::IdleW-1:0]  idle_q;

	// Result register
	logic                       out_valid_q;
	logic [kcl_pkg::OutDataW-1:0] out_data_q;

	logic [kcl_pkg::SlotW-1:0]  slot [kcl_pkg::SlotsMax];
	logic [CODE_SLOTS-1:0]      hit;
	logic [1:0]                 hit_type;
	logic                       any_hit;
	logic [CntW-1:0]            count_d;
	logic [kcl_pkg::IdleW-1:0]  idle_d;
	logic [kcl_pkg::IdleW-1:0]  idle_inc;
	logic                       digit_we;
	logic [kcl_pkg::ToneW-1:0]  tone;
	logic                       open1, open2;

	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_a_q   <= '0;
			slots_b_q   <= '0;
			slots_c_q   <= '0;
			slot_last_q <= '0;
			one_time_q  <= '0;
			two_time_q  <= '0;
			timeout_q   <= kcl_pkg::IdleTimeoutRst;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::CFG_SLOTS_A:   slots_a_q   <= cfg_data;
				kcl_pkg::CFG_SLOTS_B:   slots_b_q   <= cfg_data;
				kcl_pkg::CFG_SLOTS_C:   slots_c_q   <= cfg_data;
				kcl_pkg::CFG_SLOT_LAST: slot_last_q <= cfg_data[kcl_pkg::SlotW-1:0];
				kcl_pkg::CFG_ONE_TIME:  one_time_q  <= cfg_data[kcl_pkg::TimeW-1:0];
				kcl_pkg::CFG_TWO_TIME:  two_time_q  <= cfg_data[kcl_pkg::TimeW-1:0];
				kcl_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data[kcl_pkg::TimeW-1:0];
				default: ;
			endcase
		end
	end

	// Unpack slot table
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			slot[k]     = slots_a_q[kcl_pkg::SlotW*k +: kcl_pkg::SlotW];
			slot[k + 3] = slots_b_q[kcl_pkg::SlotW*k +: kcl_pkg::SlotW];
			slot[k + 6] = slots_c_q[kcl_pkg::SlotW*k +: kcl_pkg::SlotW];
		end
		slot[9] = slot_last_q;
	end

	// Compare the entry with every slot in parallel
	always_comb begin
		for (int k = 0; k < CODE_SLOTS; k++) begin
			hit[k] = (slot[k][17:16] != 2'b00);
			for (int d = 0; d < CODE_DIGITS; d++) begin
				if (slot[k][kcl_pkg::DigitW*d +: kcl_pkg::DigitW] != digits_q[d]) hit[k] = 1'b0;
			end
		end
		any_hit  = |hit;
		hit_type = 2'b00;
		for (int k = CODE_SLOTS - 1; k >= 0; k--) begin
			if (hit[k]) hit_type = slot[k][17:16];
		end
	end

	assign idle_inc = (idle_q != kcl_pkg::IdleMax) ? idle_q + 1'b1 : idle_q;

	// Next entry state and tone
	always_comb begin
		count_d  = count_q;
		idle_d   = idle_q;
		digit_we = 1'b0;
		tone     = kcl_pkg::ToneNone;
		open1    = 1'b0;
		open2    = 1'b0;
		case (head.cmd.act)
			kcl_pkg::ACT_TICK: begin
				idle_d = idle_inc;
				if (count_q != '0 && idle_inc > {1'b0, timeout_q}) begin
					idle_d  = '0;
					count_d = '0;
					tone    = kcl_pkg::ToneEmpty;
				end
			end
			kcl_pkg::ACT_DELETE: begin
				idle_d = '0;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
					tone    = kcl_pkg::ToneBeep;
				end else begin
					tone = kcl_pkg::ToneEmpty;
				end
			end
			kcl_pkg::ACT_CONFIRM: begin
				idle_d  = '0;
				count_d = '0;
				if (count_q == Full && any_hit) begin
					tone  = kcl_pkg::ToneOk;
					open1 = hit_type[0];
					open2 = hit_type[1];
				end else begin
					tone = kcl_pkg::ToneErr;
				end
			end
			kcl_pkg::ACT_DIGIT, kcl_pkg::ACT_OTHER: begin
				idle_d = '0;
				if (count_q >= Full) begin
					tone    = kcl_pkg::ToneErr;
					count_d = '0;
				end else if (head.cmd.act == kcl_pkg::ACT_DIGIT) begin
					digit_we = 1'b1;
					count_d  = count_q + 1'b1;
					tone     = kcl_pkg::ToneBeep;
				end
			end
			default: ;
		endcase
	end

	// Update entry state on each popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idle_q  <= '0;
		end else if (pop) begin
			count_q <= count_d;
			idle_q  <= idle_d;
		end
	end

	// Append digit
	always_ff @(posedge clk) begin
		if (pop && digit_we) digits_q[count_q[IdxW-1:0]] <= head.cmd.digit;
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {kcl_pkg::LenW'(count_d),
				(open2 ? two_time_q : kcl_pkg::TimeW'(0)), open2,
				(open1 ? one_time_q : kcl_pkg::TimeW'(0)), open1,
				tone};
		end
	end

endmodule

@@ design/keypad_code_lock.sv @@
// Channel   Dir  Handshake               Contents
// s_axis    in   s_axis_tvalid/tready    key event or 1 ms tick
// m_axis    out  m_axis_tvalid/tready    tone, lock openings, entry length
// cfg       in   cfg_we                  code slots, unlock times, idle timeout
//
// One word per cycle sustained while the output is not stalled.
// Front end decodes the word into a two-entry queue; back end updates the entry
// and compares all code slots in parallel, then holds the result in an output register.
// A stalled output fills the queue, after which s_axis_tready drops.
// Reset clears entry/idle counts and configuration, timeout to default; no clearing pass.
module keypad_code_lock #(
	parameter int CODE_DIGITS = kcl_pkg::DefCodeDigits,
	parameter int CODE_SLOTS  = kcl_pkg::DefCodeSlots
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [3:0] key_code, [4] key_pressed, [7:5] zero
	input  logic [kcl_pkg::InDataW-1:0]   s_axis_tdata,
	// [0] opcode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [2:0] tone, [3] open_lock_one, [19:4] lock_one_duration,
	// [20] open_lock_two, [36:21] lock_two_duration, [39:37] entry_length
	output logic [kcl_pkg::OutDataW-1:0]  m_axis_tdata,
	input  logic                          cfg_we,
	input  logic [kcl_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [kcl_pkg::RegW-1:0]      cfg_data
);

	kcl_pkg::cmd_t      front_cmd;
	kcl_pkg::cmd_chan_t head;
	logic               full;
	logic               push;
	logic               pop;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;

	kcl_front u_front (
		.opcode      (s_axis_tuser),
		.key_code    (s_axis_tdata[3:0]),
		.key_pressed (s_axis_tdata[4]),
		.cmd         (front_cmd)
	);

	kcl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	kcl_back #(
		.CODE_DIGITS (CODE_DIGITS),
		.CODE_SLOTS  (CODE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ tb/tb_keypad_code_lock.sv @@
`timescale 1ns / 1ps

module tb_keypad_code_lock;

	localparam int Digits = kcl_pkg::DefCodeDigits;
	localparam int Slots  = kcl_pkg::DefCodeSlots;
	localparam int GapMax = 12;
	localparam int PhaseWords = 175;
	localparam int RandomPhases = 8;
	localparam int CycleLimit = 200_000;

	localparam logic OpKey  = 1'b0;
	localparam logic OpTick = 1'b1;
	localparam logic [3:0] KeyOtherLo = 4'd14;
	localparam logic [3:0] KeyOtherHi = 4'd15;

	// One result word, laid out as on m_axis_tdata
	typedef struct packed {
		logic [kcl_pkg::LenW-1:0]  len;
		logic [kcl_pkg::TimeW-1:0] two_dur;
		logic                      two_open;
		logic [kcl_pkg::TimeW-1:0] one_dur;
		logic                      one_open;
		logic [kcl_pkg::ToneW-1:0] tone;
	} lock_result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [kcl_pkg::InDataW-1:0]  s_axis_tdata;
	logic                         s_axis_tuser;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [kcl_pkg::OutDataW-1:0] m_axis_tdata;
	logic                         cfg_we;
	logic [kcl_pkg::CfgIdxW-1:0]  cfg_index;
	logic [kcl_pkg::RegW-1:0]     cfg_data;

	// Mirror of the lock configuration and entry state
	logic [kcl_pkg::RegW-1:0]   slots_a, slots_b, slots_c;
	logic [kcl_pkg::SlotW-1:0]  slot_last;
	logic [kcl_pkg::TimeW-1:0]  one_time, two_time, timeout_ticks;
	logic [kcl_pkg::DigitW-1:0] typed_digits [kcl_pkg::DigitsMax];
	int unsigned                typed_count;
	logic [kcl_pkg::IdleW-1:0]  quiet_ticks;

	lock_result_t result_q[$];
	int           fail_count;
	int           result_seq;
	int           live_words;
	bit           src_idle_on;
	bit           sink_idle_on;

	keypad_code_lock #(
		.CODE_DIGITS(Digits),
		.CODE_SLOTS (Slots)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	function automatic logic [kcl_pkg::SlotW-1:0] make_slot(logic [1:0] kind, logic [3:0] d0,
			logic [3:0] d1, logic [3:0] d2, logic [3:0] d3);
		return {kind, d3, d2, d1, d0};
	endfunction

	function automatic logic [kcl_pkg::SlotW-1:0] slot_entry(int k);
		if (k < 3)
			return slots_a[kcl_pkg::SlotW*k +: kcl_pkg::SlotW];
		else if (k < 6)
			return slots_b[kcl_pkg::SlotW*(k-3) +: kcl_pkg::SlotW];
		else if (k < 9)
			return slots_c[kcl_pkg::SlotW*(k-6) +: kcl_pkg::SlotW];
		return slot_last;
	endfunction

	// Advance the entry state by one word and return the result it yields
	function automatic lock_result_t step_lock(logic op, logic [3:0] key, logic pressed);
		lock_result_t r;
		logic [kcl_pkg::SlotW-1:0] s;
		bit hit;
		bit same;
		r = '0;
		hit = 1'b0;
		if (op == OpTick) begin
			if (quiet_ticks != kcl_pkg::IdleMax)
				quiet_ticks++;
			if (typed_count != 0 && quiet_ticks > {1'b0, timeout_ticks}) begin
				quiet_ticks = '0;
				typed_count = 0;
				r.tone = kcl_pkg::ToneEmpty;
			end
		end else if (pressed) begin
			case (key)
				kcl_pkg::KeyDelete: begin
					quiet_ticks = '0;
					if (typed_count > 0) begin
						typed_count--;
						r.tone = kcl_pkg::ToneBeep;
					end else begin
						r.tone = kcl_pkg::ToneEmpty;
					end
				end
				kcl_pkg::KeyConfirm: begin
					quiet_ticks = '0;
					if (typed_count != Digits) begin
						r.tone = kcl_pkg::ToneErr;
					end else begin
						// first slot with matching digits and a nonzero type wins
						for (int k = 0; k < Slots; k++) begin
							if (!hit) begin
								s = slot_entry(k);
								same = 1'b1;
								for (int d = 0; d < Digits; d++)
									if (s[kcl_pkg::DigitW*d +: kcl_pkg::DigitW] !=
											typed_digits[d])
										same = 1'b0;
								if (same && s[17:16] != 2'b00) begin
									r.one_open = s[16];
									r.two_open = s[17];
									hit = 1'b1;
								end
							end
						end
						r.tone = hit ? kcl_pkg::ToneOk : kcl_pkg::ToneErr;
					end
					typed_count = 0;
				end
				kcl_pkg::KeyFamLeft, kcl_pkg::KeyFamRight: begin
				end
				default: begin
					quiet_ticks = '0;
					if (typed_count >= Digits) begin
						r.tone = kcl_pkg::ToneErr;
						typed_count = 0;
					end else if (key <= kcl_pkg::KeyLastDigit) begin
						typed_digits[typed_count] = key;
						typed_count++;
						r.tone = kcl_pkg::ToneBeep;
					end
				end
			endcase
		end
		r.one_dur = r.one_open ? one_time : '0;
		r.two_dur = r.two_open ? two_time : '0;
		r.len = kcl_pkg::LenW'(typed_count);
		return r;
	endfunction

	// Offer one word, after a random gap when source idling is on, and hold it until taken
	task automatic send_word(logic op, logic [3:0] key, logic pressed);
		int gap;
		gap = src_idle_on ? $urandom_range(0, GapMax) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {3'b000, pressed, key};
		s_axis_tuser = op;
		do @(posedge clk); while (!s_axis_tready);
		result_q.push_back(step_lock(op, key, pressed));
		if (op == OpTick || (pressed && key != kcl_pkg::KeyFamLeft &&
				key != kcl_pkg::KeyFamRight))
			live_words++;
	endtask

	task automatic press(logic [3:0] key);
		send_word(OpKey, key, 1'b1);
	endtask

	// Key and press fields carry no meaning on a tick; fill them at random
	task automatic send_tick();
		send_word(OpTick, 4'($urandom), 1'($urandom));
	endtask

	task automatic send_noise();
		logic op;
		op = ($urandom_range(0, 9) < 4) ? OpTick : OpKey;
		send_word(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 5) != 0));
	endtask

	// Hold the sender until every pending result has been checked
	task automatic wait_results_done();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(kcl_pkg::cfg_idx_t idx, logic [kcl_pkg::RegW-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			kcl_pkg::CFG_SLOTS_A:   slots_a = value;
			kcl_pkg::CFG_SLOTS_B:   slots_b = value;
			kcl_pkg::CFG_SLOTS_C:   slots_c = value;
			kcl_pkg::CFG_SLOT_LAST: slot_last = value[kcl_pkg::SlotW-1:0];
			kcl_pkg::CFG_ONE_TIME:  one_time = value[kcl_pkg::TimeW-1:0];
			kcl_pkg::CFG_TWO_TIME:  two_time = value[kcl_pkg::TimeW-1:0];
			kcl_pkg::CFG_TIMEOUT:   timeout_ticks = value[kcl_pkg::TimeW-1:0];
			default: begin
			end
		endcase
	endtask

	// Result sink: random stall before each word when sink idling is on
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			stall = sink_idle_on ? $urandom_range(0, GapMax) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic check_field(string name, logic [kcl_pkg::TimeW-1:0] want,
			logic [kcl_pkg::TimeW-1:0] got);
		if (got !== want)
			note_failure($sformatf("result %0d: %s expected %0h, got %0h",
				result_seq, name, want, got));
	endtask

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		lock_result_t got;
		lock_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (result_q.size() == 0) begin
				note_failure($sformatf("result %0d: unexpected word %h", result_seq, got));
			end else begin
				want = result_q.pop_front();
				check_field("tone", kcl_pkg::TimeW'(want.tone), kcl_pkg::TimeW'(got.tone));
				check_field("open_lock_one", kcl_pkg::TimeW'(want.one_open),
					kcl_pkg::TimeW'(got.one_open));
				check_field("lock_one_duration", want.one_dur, got.one_dur);
				check_field("open_lock_two", kcl_pkg::TimeW'(want.two_open),
					kcl_pkg::TimeW'(got.two_open));
				check_field("lock_two_duration", want.two_dur, got.two_dur);
				check_field("entry_length", kcl_pkg::TimeW'(want.len),
					kcl_pkg::TimeW'(got.len));
			end
			result_seq++;
		end
	end

	// Idle timeout at a small limit, with family keys, and at the low end
	task automatic test_idle_timeout();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		// all slots empty after reset: even a code of zeros fails
		repeat (Digits) press(4'd0);
		press(kcl_pkg::KeyConfirm);
		wait_results_done();
		write_reg(kcl_pkg::CFG_TIMEOUT, kcl_pkg::RegW'(20));
		// the entry clears on the first tick past the limit
		press(4'd5);
		repeat (20) send_tick();
		send_tick();
		// family keys leave the idle count running
		press(4'd7);
		repeat (10) send_tick();
		press(kcl_pkg::KeyFamLeft);
		repeat (10) send_tick();
		send_tick();
		// ticks on an empty entry only count
		repeat (30) send_tick();
		press(4'd2);
		send_tick();
		wait_results_done();
		write_reg(kcl_pkg::CFG_TIMEOUT, '0);
		send_tick();
		press(4'd3);
		send_tick();
		wait_results_done();
		write_reg(kcl_pkg::CFG_TIMEOUT, kcl_pkg::RegW'(1));
		press(4'd8);
		send_tick();
		send_tick();
		wait_results_done();
	endtask

	// Every key class, slot order and the full-buffer cases
	task automatic test_directed();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		write_reg(kcl_pkg::CFG_SLOTS_A, {make_slot(2'b01, 4'd9, 4'd9, 4'd9, 4'd9),
			make_slot(2'b10, 4'd1, 4'd2, 4'd3, 4'd4),
			make_slot(2'b00, 4'd1, 4'd2, 4'd3, 4'd4)});
		write_reg(kcl_pkg::CFG_SLOTS_B, '0);
		write_reg(kcl_pkg::CFG_SLOTS_C, {make_slot(2'b11, 4'd5, 4'd6, 4'd7, 4'd8), 36'd0});
		write_reg(kcl_pkg::CFG_SLOT_LAST,
			kcl_pkg::RegW'(make_slot(2'b11, 4'd0, 4'd0, 4'd0, 4'd0)));
		write_reg(kcl_pkg::CFG_ONE_TIME, kcl_pkg::RegW'(16'hFFFF));
		write_reg(kcl_pkg::CFG_TWO_TIME, kcl_pkg::RegW'(16'h0001));
		send_word(OpKey, 4'd5, 1'b0);
		press(kcl_pkg::KeyFamLeft);
		press(kcl_pkg::KeyFamRight);
		press(KeyOtherLo);
		press(kcl_pkg::KeyDelete);
		press(kcl_pkg::KeyConfirm);
		press(4'd3);
		press(KeyOtherHi);
		press(kcl_pkg::KeyConfirm);
		// slot 0 matches but is empty, so slot 1 opens lock 2
		press(4'd1);
		press(4'd2);
		press(4'd3);
		press(4'd4);
		press(kcl_pkg::KeyConfirm);
		repeat (Digits) press(kcl_pkg::KeyLastDigit);
		press(4'd0);
		repeat (Digits) press(4'd0);
		press(kcl_pkg::KeyDelete);
		press(4'd0);
		press(kcl_pkg::KeyConfirm);
		send_tick();
		wait_results_done();
	endtask

	// Enter a code taken from a slot, sometimes spoiled, mostly confirmed
	task automatic enter_slot_code();
		logic [kcl_pkg::SlotW-1:0] s;
		logic [3:0] dg;
		int n;
		s = slot_entry($urandom_range(0, Slots - 1));
		dg = '0;
		if (typed_count != 0 && $urandom_range(0, 3) != 0) begin
			n = typed_count;
			repeat (n) press(kcl_pkg::KeyDelete);
		end
		for (int d = 0; d < Digits; d++) begin
			dg = s[kcl_pkg::DigitW*d +: kcl_pkg::DigitW];
			if (dg > kcl_pkg::KeyLastDigit || $urandom_range(0, 9) == 0)
				dg = 4'($urandom_range(0, 9));
			press(dg);
			if ($urandom_range(0, 11) == 0)
				send_noise();
		end
		if ($urandom_range(0, 7) == 0) begin
			press(kcl_pkg::KeyDelete);
			press(dg);
		end
		case ($urandom_range(0, 11))
			0: press(4'($urandom_range(0, 15)));
			1: begin
			end
			default: press(kcl_pkg::KeyConfirm);
		endcase
	endtask

	function automatic logic [kcl_pkg::SlotW-1:0] random_slot();
		logic [kcl_pkg::SlotW-1:0] s;
		s = '0;
		for (int d = 0; d < Digits; d++)
			s[kcl_pkg::DigitW*d +: kcl_pkg::DigitW] = ($urandom_range(0, 15) == 0) ?
				4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
		s[17:16] = 2'($urandom_range(0, 3));
		return s;
	endfunction

	function automatic logic [kcl_pkg::TimeW-1:0] random_time();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return kcl_pkg::TimeW'($urandom);
		endcase
	endfunction

	// Draw a fresh configuration: extremes now and then, else codes worth typing
	task automatic load_random_config();
		logic [kcl_pkg::SlotW-1:0] pool [kcl_pkg::SlotsMax];
		logic [kcl_pkg::TimeW-1:0] limit;
		int mode;
		mode = $urandom_range(0, 5);
		for (int k = 0; k < kcl_pkg::SlotsMax; k++) begin
			pool[k] = random_slot();
			// repeat an earlier code so slot order decides
			if (k > 0 && $urandom_range(0, 3) == 0)
				pool[k][15:0] = pool[$urandom_range(0, k - 1)][15:0];
		end
		if (mode == 0) begin
			write_reg(kcl_pkg::CFG_SLOTS_A, '0);
			write_reg(kcl_pkg::CFG_SLOTS_B, '0);
			write_reg(kcl_pkg::CFG_SLOTS_C, '0);
			write_reg(kcl_pkg::CFG_SLOT_LAST, '0);
		end else if (mode == 1) begin
			write_reg(kcl_pkg::CFG_SLOTS_A, '1);
			write_reg(kcl_pkg::CFG_SLOTS_B, '1);
			write_reg(kcl_pkg::CFG_SLOTS_C, '1);
			write_reg(kcl_pkg::CFG_SLOT_LAST, kcl_pkg::RegW'({kcl_pkg::SlotW{1'b1}}));
		end else begin
			write_reg(kcl_pkg::CFG_SLOTS_A, {pool[2], pool[1], pool[0]});
			write_reg(kcl_pkg::CFG_SLOTS_B, {pool[5], pool[4], pool[3]});
			write_reg(kcl_pkg::CFG_SLOTS_C, {pool[8], pool[7], pool[6]});
			write_reg(kcl_pkg::CFG_SLOT_LAST, kcl_pkg::RegW'(pool[9]));
		end
		write_reg(kcl_pkg::CFG_ONE_TIME, kcl_pkg::RegW'(random_time()));
		write_reg(kcl_pkg::CFG_TWO_TIME, kcl_pkg::RegW'(random_time()));
		case ($urandom_range(0, 5))
			0: limit = '0;
			1: limit = 16'd1;
			2: limit = '1;
			default: limit = kcl_pkg::TimeW'($urandom_range(2, 40));
		endcase
		write_reg(kcl_pkg::CFG_TIMEOUT, kcl_pkg::RegW'(limit));
	endtask

	// Random phases, each under its own configuration and idling mix
	task automatic test_random();
		int phase_start;
		for (int p = 0; p < RandomPhases; p++) begin
			wait_results_done();
			load_random_config();
			src_idle_on = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			phase_start = live_words;
			while (live_words - phase_start < PhaseWords) begin
				if ($urandom_range(0, 9) < 5)
					enter_slot_code();
				else
					send_noise();
			end
		end
		wait_results_done();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kcl_pkg::CFG_SLOTS_A;
		cfg_data = '0;
		slots_a = '0;
		slots_b = '0;
		slots_c = '0;
		slot_last = '0;
		one_time = '0;
		two_time = '0;
		timeout_ticks = kcl_pkg::IdleTimeoutRst;
		for (int d = 0; d < kcl_pkg::DigitsMax; d++)
			typed_digits[d] = '0;
		typed_count = 0;
		quiet_ticks = '0;
		fail_count = 0;
		result_seq = 0;
		live_words = 0;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_timeout();
		test_directed();
		test_random();
		repeat (4) @(posedge clk);

		if (fail_count == 0 && result_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ keypad_code_lock.f @@
design/kcl_pkg.sv
design/kcl_front.sv
design/kcl_queue.sv
design/kcl_back.sv
design/keypad_code_lock.sv
tb/tb_keypad_code_lock.sv
